// File: sv/wmpp_pkg.sv
package wmpp_pkg;

   // Window storage depth and derived widths
   localparam int WINDOW_DEPTH = 64;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W     = 16;
   localparam int FILL_W       = 7;
   localparam int WLEN_W       = 7;
   localparam int WLEN_RESET   = 64;

   // Running sum of up to WINDOW_DEPTH samples
   localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int DIVCNT_W     = $clog2(SUM_W + 1);

   // Stream payload widths (packed, padded to bytes)
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_FIELDS_W = FILL_W + SAMPLE_W + SAMPLE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register file
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// File: sv/window_mean_peak_to_peak.sv
// Sliding-window mean and peak-to-peak of signed Q8.8 samples. Each accepted
// item is written into a ring window of window_length samples (0 acts as 1,
// values above 64 act as 64); writing window_length empties the window. Per
// item one result comes out: fill count, mean (truncated toward zero) and
// max minus min of the held samples. After each accept the block works
// through these steps in order: the single read port of the window memory
// yields one held sample per cycle for the sum/min/max scan, a drain step
// empties the read pipeline, a prep step loads the divider, a restoring
// divider then works out the mean bit by bit over the 22-bit sum, and a done
// step loads the result once the output register is free. req_tready is low
// from the accept until the result is loaded; the result waits in that
// register, so the next item can be taken while it is still unread.
module window_mean_peak_to_peak (
   input  logic                               clock,
   input  logic                               reset,
   // item in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wmpp_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] sample
   // result out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] fill_count, [22:7] mean_value, [38:23] peak_to_peak, [39] zero
   output logic [wmpp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wmpp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wmpp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wmpp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wmpp_pkg::*;

   state_type state_ff, state_in;

   logic [WLEN_W-1:0]           wlen_ff;
   logic [SLOT_W-1:0]           wslot_ff;
   logic [CNT_W-1:0]            held_ff;
   logic [SLOT_W-1:0]           scan_idx_ff;
   logic                        rd_valid_ff;
   logic                        first_ff;
   logic signed [SAMPLE_W-1:0]  rd_data_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [SAMPLE_W-1:0]  lo_ff, hi_ff;
   logic [SUM_W-1:0]            quo_ff;
   logic [CNT_W-1:0]            rem_ff;
   logic                        neg_ff;
   logic [DIVCNT_W-1:0]         div_cnt_ff;
   logic                        rsp_valid_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff;

   logic signed [SAMPLE_W-1:0]  sample_store [WINDOW_DEPTH];

   logic                        accept;
   logic                        csr_wr;
   logic                        out_load;
   logic                        scan_last;
   logic [CNT_W-1:0]            active_len;
   logic [CNT_W-1:0]            slot_next;
   logic [CNT_W:0]              div_shift;
   logic [CNT_W+1:0]            div_trial;
   logic [SUM_W-1:0]            mean_full;
   logic [SAMPLE_W-1:0]         p2p;

   // Handshakes
   assign accept     = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Register read
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1 -: CSR_INDEX_W] == CSR_WINDOW_LENGTH) begin
         csr_prdata = CSR_DATA_W'(wlen_ff);
      end
   end

   // Effective window length, clamped to 1..WINDOW_DEPTH
   always_comb begin
      if (wlen_ff == '0) begin
         active_len = CNT_W'(1);
      end else if (32'(wlen_ff) > WINDOW_DEPTH) begin
         active_len = CNT_W'(WINDOW_DEPTH);
      end else begin
         active_len = CNT_W'(wlen_ff);
      end
   end

   assign slot_next = CNT_W'(wslot_ff) + CNT_W'(1);
   assign scan_last = (CNT_W'(scan_idx_ff) == held_ff - CNT_W'(1));

   // One restoring divide step
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_trial = {1'b0, div_shift} - {2'b0, held_ff};

   assign mean_full = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   assign p2p       = SAMPLE_W'(hi_ff - lo_ff);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SCAN;
         ST_SCAN:  if (scan_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (div_cnt_ff == DIVCNT_W'(1)) state_in = ST_DONE;
         ST_DONE:  if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Window control: length register, write slot, fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= WLEN_W'(WLEN_RESET);
         wslot_ff <= '0;
         held_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[CSR_ADDR_W-1 -: CSR_INDEX_W] == CSR_WINDOW_LENGTH) begin
            wlen_ff  <= csr_pwdata[WLEN_W-1:0];
            wslot_ff <= '0;
            held_ff  <= '0;
         end
      end else if (accept) begin
         wslot_ff <= (slot_next >= active_len) ? '0 : SLOT_W'(slot_next);
         if (held_ff < active_len) begin
            held_ff <= held_ff + CNT_W'(1);
         end
      end
   end

   // Window memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_store[wslot_ff] <= signed'(req_tdata[SAMPLE_W-1:0]);
      end
      rd_data_ff <= sample_store[scan_idx_ff];
   end

   // Scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SCAN);
         if (accept) begin
            scan_idx_ff <= '0;
            first_ff    <= 1'b1;
         end else begin
            if (state_ff == ST_SCAN) scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
            if (rd_valid_ff) first_ff <= 1'b0;
         end
      end
   end

   // Sum, min and max over the streamed samples
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if (first_ff) begin
            sum_ff <= SUM_W'(rd_data_ff);
            lo_ff  <= rd_data_ff;
            hi_ff  <= rd_data_ff;
         end else begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
            if (rd_data_ff < lo_ff) lo_ff <= rd_data_ff;
            if (rd_data_ff > hi_ff) hi_ff <= rd_data_ff;
         end
      end
   end

   // Divider: |sum| / fill count, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (state_ff == ST_PREP) begin
         div_cnt_ff <= DIVCNT_W'(SUM_W);
      end else if (state_ff == ST_DIV) begin
         div_cnt_ff <= div_cnt_ff - DIVCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         neg_ff <= sum_ff[SUM_W-1];
         quo_ff <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         if (!div_trial[CNT_W+1]) begin
            rem_ff <= CNT_W'(div_trial);
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= CNT_W'(div_shift);
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= RSP_DATA_W'({p2p, mean_full[SAMPLE_W-1:0], FILL_W'(held_ff)});
      end
   end

   // Checks
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted item did not start a scan");

   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      held_ff <= active_len)
      else $error("fill count exceeds window length");

   a_slot_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wslot_ff) < active_len)
      else $error("write slot outside window");

   a_busy_has_samples: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> held_ff != '0)
      else $error("processing with an empty window");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < held_ff)
      else $error("divider remainder not below divisor");

endmodule

// File: verif/tb_top.sv
module tb_top;
   import wmpp_pkg::*;

   // register indexes; only window_length exists, index 1 decodes to nothing
   localparam int IDX_WINDOW_LENGTH = int'(CSR_WINDOW_LENGTH);
   localparam int IDX_UNUSED        = 1;
   localparam int CSR_STRIDE        = 4;

   localparam int RANDOM_PHASES     = 12;
   localparam int ITEMS_PER_PHASE   = 135;
   localparam int SETTLE_CYCLES     = 100;

   typedef struct packed {
      logic [FILL_W-1:0]          fill;
      logic signed [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0]        spread;
   } window_stats_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [15:0] sample
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [6:0] fill_count, [22:7] mean_value, [38:23] peak_to_peak, [39] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // predictor state: window contents, next slot, fill and length register
   logic signed [SAMPLE_W-1:0] win_store [WINDOW_DEPTH];
   int                         win_slot;
   int                         win_held;
   logic [WLEN_W-1:0]          win_length;

   window_stats_t expected_stats[$];
   int            mismatch_count;
   int            stall_left;
   bit            req_gaps_on;
   bit            rsp_stalls_on;
   logic [SAMPLE_W-1:0] drift_base;

   window_mean_peak_to_peak dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   // mostly short delays, a few long ones
   function automatic int pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   // mix of full-range, small, extreme and slowly drifting samples
   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return SAMPLE_W'($urandom());
      if (pick < 7) return SAMPLE_W'($urandom_range(0, 511) - 256);
      if (pick == 7) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
         endcase
      end
      return SAMPLE_W'(int'($signed(drift_base)) + $urandom_range(0, 15) - 8);
   endfunction

   // write the sample into the ring, then scan the held slots
   function automatic window_stats_t predict_stats(logic [SAMPLE_W-1:0] s);
      window_stats_t res;
      int len;
      int sum;
      int lo;
      int hi;
      int v;
      len = int'(win_length);
      if (len < 1) len = 1;
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
      if (win_slot >= len) win_slot = 0;
      if (win_held > len) win_held = len;
      win_store[win_slot] = s;
      win_slot++;
      if (win_slot >= len) win_slot = 0;
      if (win_held < len) win_held++;
      sum = 0;
      lo = win_store[0];
      hi = win_store[0];
      for (int i = 0; i < win_held; i++) begin
         v = win_store[i];
         sum += v;
         if (v < lo) lo = v;
         if (v > hi) hi = v;
      end
      res.fill   = FILL_W'(win_held);
      res.mean   = SAMPLE_W'(sum / win_held);
      res.spread = SAMPLE_W'(hi - lo);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // result side: random backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_delay();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      window_stats_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("result with nothing pending", 0, 0);
         end else begin
            want = expected_stats.pop_front();
            if (rsp_tdata[6:0] !== want.fill)
               report_mismatch("fill_count", rsp_tdata[6:0], want.fill);
            if (rsp_tdata[22:7] !== want.mean)
               report_mismatch("mean_value", longint'($signed(rsp_tdata[22:7])),
                               longint'(want.mean));
            if (rsp_tdata[38:23] !== want.spread)
               report_mismatch("peak_to_peak", rsp_tdata[38:23], want.spread);
         end
      end
   end

   // one item: optional gap, then hold valid until accepted
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = req_gaps_on ? pick_delay() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_stats.push_back(predict_stats(s));
   endtask

   // stop sending and let every pending result come back
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup + access cycle; the predictor follows the register
   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * CSR_STRIDE);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == IDX_WINDOW_LENGTH) begin
         win_length = data[WLEN_W-1:0];
         win_slot   = 0;
         win_held   = 0;
      end
   endtask

   task automatic set_window(input int len);
      wait_results_drained();
      csr_write(IDX_WINDOW_LENGTH, ($urandom() & ~32'h7f) | CSR_DATA_W'(len));
   endtask

   // full-scale values in the default 64-deep window
   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] vals [10];
      vals = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001,
               16'h5555, 16'haaaa, 16'h7fff, 16'h8000, 16'h0100};
      foreach (vals[i]) send_sample(vals[i]);
   endtask

   // zero acts as one, above depth acts as depth, length write empties window
   task automatic test_length_limits();
      set_window(0);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h1234);
      set_window(127);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'hfff0);
      set_window(2);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h0003);
      send_sample(16'hfffd);
   endtask

   // a write to an undecoded index must not touch the window
   task automatic test_unknown_register();
      wait_results_drained();
      csr_write(IDX_UNUSED, 32'h0000_0005);
      send_sample(16'h4000);
      send_sample(16'hc000);
   endtask

   // random streams over a range of window lengths
   task automatic test_random_windows();
      int lens [RANDOM_PHASES];
      lens = '{64, 1, 2, 3, 0, 8, 17, 127, 63, 64, 33, 5};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 9) lens[p] = $urandom_range(0, 127);
         set_window(lens[p]);
         req_gaps_on   = (p % 4 != 3);
         rsp_stalls_on = (p % 4 != 3) && (p != 6);
         drift_base    = SAMPLE_W'($urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold off mid-phase until the block has caught up
            if (p == 5 && n == 60) wait_results_drained();
            send_sample(rand_sample());
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      stall_left    = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      drift_base    = '0;
      mismatch_count = 0;
      win_length    = WLEN_W'(WLEN_RESET);
      win_slot      = 0;
      win_held      = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_sample_extremes();
      test_length_limits();
      test_unknown_register();
      test_random_windows();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_stats.size() != 0)
         report_mismatch("results never delivered", 0, expected_stats.size());
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
